// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSKTC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define LSKTC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define LSKTC_ASSERT(lbl, clk, rstn, prop, msg)
`define LSKTC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/core/lsktc_pkg.sv =====
// ---------------------------------------------------------------------------
// lsktc_pkg
// Types and constants of the size-keyed LRU target cache.
// ---------------------------------------------------------------------------
package lsktc_pkg;

    localparam int unsigned LSKTC_MAX_ENTRIES = 8;
    localparam int unsigned DIM_BITS          = 14;
    localparam int unsigned CAP_W             = 4;
    localparam int unsigned SLOT_W            = 3;
    localparam int unsigned LIVE_W            = 4;
    localparam int unsigned CNT_W             = 32;
    localparam logic [CAP_W-1:0] CAP_RESET    = 4'd8;

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_FLUSH   = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        logic                create_ok;
    } lsktc_req_t;

    typedef struct packed {
        logic                hit;
        logic                granted;
        logic [SLOT_W-1:0]   slot;
        logic                evicted;
        logic [DIM_BITS-1:0] evicted_width;
        logic [DIM_BITS-1:0] evicted_height;
        logic [CNT_W-1:0]    hit_total;
        logic [CNT_W-1:0]    miss_total;
        logic [CNT_W-1:0]    eviction_total;
        logic [CNT_W-1:0]    allocation_total;
        logic [LIVE_W-1:0]   live_entries;
    } lsktc_rsp_t;

    // Command broadcast to every cell
    typedef enum logic [1:0] {
        OP_NOP,
        OP_PROMOTE,
        OP_INSERT,
        OP_FLUSH
    } lsktc_op_t;

    typedef struct packed {
        lsktc_op_t           op;
        logic [DIM_BITS-1:0] key_w;
        logic [DIM_BITS-1:0] key_h;
    } lsktc_cmd_t;

    // Data handed from one cell to the next
    typedef struct packed {
        logic                free_seen;
        logic [DIM_BITS-1:0] vic_w;
        logic [DIM_BITS-1:0] vic_h;
    } lsktc_link_t;

endpackage

// ===== rtl/core/lru_size_keyed_target_cache.sv =====
// ---------------------------------------------------------------------------
// lru_size_keyed_target_cache
// Fully associative LRU tag store keyed by (width, height).
// ---------------------------------------------------------------------------
// Requests arrive on s_valid/s_ready/s_data: kind 0 acquires a target for a
// size, kind 1 flushes every entry. Each request yields exactly one response
// on m_valid/m_ready/m_data with hit, grant, slot, eviction details, the four
// running 32-bit counters and the live entry count.
// The store is a row of MAX_ENTRIES cells. A request passes a search state
// (all cells compare the key, the row ripples the lowest free slot and the
// victim key) and then an update state (one command broadcast to all
// cells), whose end registers the response and sets m_valid. A new request
// is taken in the update state as the last one completes.
// The response sits in an output register; while the receiver stalls it a
// finished search holds in update and the cells do not change.
// cfg_wr_en/cfg_wr_data write the capacity (0 acts as 1, values above
// MAX_ENTRIES act as MAX_ENTRIES); write it only while the block is idle.
// Reset empties the store, zeroes the counters and sets capacity to 8.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_size_keyed_target_cache
    import lsktc_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = LSKTC_MAX_ENTRIES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lsktc_req_t       s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lsktc_rsp_t       m_data,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data
);

    localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;
    localparam int unsigned SW = (IW > SLOT_W) ? IW : SLOT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    state_t               state_reg;
    lsktc_req_t           req_reg;
    logic [CAP_W-1:0]     cap_reg;
    logic [CW-1:0]        live_reg;
    logic [CNT_W-1:0]     hits_reg, misses_reg, evicts_reg, allocs_reg;
    logic                 m_valid_reg;
    lsktc_rsp_t           m_data_reg;

    // search results
    logic                   hit_reg;
    logic [MAX_ENTRIES-1:0] hit_oh_reg;
    logic [IW-1:0]          hit_rank_reg;
    logic                   free_any_reg;
    logic [MAX_ENTRIES-1:0] free_oh_reg;
    logic [MAX_ENTRIES-1:0] vic_oh_reg;
    logic [DIM_BITS-1:0]    vic_w_reg, vic_h_reg;

    // cell row
    lsktc_cmd_t             cmd;
    logic [IW-1:0]          cmd_rank;
    logic [MAX_ENTRIES-1:0] sel_vec;
    lsktc_link_t            link [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] hit_vec, free_vec, vic_vec;
    logic [IW-1:0]          rank_vec [MAX_ENTRIES];

    logic                   out_free, advance;
    logic [LW-1:0]          cap_ext, cap_eff, live_ext, evict_n, live_new;
    logic [IW-1:0]          capm1;
    logic [IW-1:0]          hit_rank_c;
    logic                   is_flush, insert;
    logic [MAX_ENTRIES-1:0] dst_oh;
    logic [SW-1:0]          hit_idx, dst_idx;
    lsktc_rsp_t             rsp_c;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = (state_reg == ST_UPDATE) && out_free;
    assign s_ready  = (state_reg == ST_IDLE) || advance;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Effective capacity and the rank at which eviction starts
    always_comb begin
        cap_ext = LW'(cap_reg);
        if (cap_ext == '0) begin
            cap_eff = LW'(1);
        end else if (cap_ext > LW'(MAX_ENTRIES)) begin
            cap_eff = LW'(MAX_ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
        capm1 = IW'(cap_eff - LW'(1));
    end

    // Decode the pending request
    always_comb begin
        is_flush = (req_reg.kind == KIND_FLUSH);
        insert   = !is_flush && !hit_reg && (req_reg.width != '0)
                   && (req_reg.height != '0) && req_reg.create_ok;
        live_ext = LW'(live_reg);
        evict_n  = '0;
        if (insert && (live_ext >= cap_eff)) begin
            evict_n = live_ext - cap_eff + LW'(1);
        end
        if (is_flush) begin
            live_new = '0;
        end else if (insert) begin
            live_new = live_ext - evict_n + LW'(1);
        end else begin
            live_new = live_ext;
        end
        dst_oh = free_any_reg ? free_oh_reg : vic_oh_reg;
        sel_vec = hit_reg ? hit_oh_reg : dst_oh;
    end

    // One-hot to index, and rank of the hit entry
    always_comb begin
        hit_idx    = '0;
        dst_idx    = '0;
        hit_rank_c = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (hit_oh_reg[i]) begin
                hit_idx = hit_idx | SW'(i);
            end
            if (dst_oh[i]) begin
                dst_idx = dst_idx | SW'(i);
            end
            if (hit_vec[i]) begin
                hit_rank_c = hit_rank_c | rank_vec[i];
            end
        end
    end

    // Command to the cells; change them only when the result can be stored
    always_comb begin
        cmd.key_w = req_reg.width;
        cmd.key_h = req_reg.height;
        cmd.op    = OP_NOP;
        if (advance) begin
            if (is_flush) begin
                cmd.op = OP_FLUSH;
            end else if (hit_reg) begin
                cmd.op = OP_PROMOTE;
            end else if (insert) begin
                cmd.op = OP_INSERT;
            end
        end
        cmd_rank = ((state_reg == ST_UPDATE) && hit_reg) ? hit_rank_reg : capm1;
    end

    assign link[0] = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lsktc_cell #(
            .IDX_W (IW)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .cmd_rank    (cmd_rank),
            .sel         (sel_vec[g]),
            .link_in     (link[g]),
            .link_out    (link[g+1]),
            .hit         (hit_vec[g]),
            .lowest_free (free_vec[g]),
            .victim      (vic_vec[g]),
            .rank        (rank_vec[g])
        );
    end

    // Response built in the update cycle
    always_comb begin
        rsp_c.hit              = hit_reg;
        rsp_c.granted          = hit_reg || insert;
        rsp_c.slot             = hit_reg ? hit_idx[SLOT_W-1:0]
                                 : (insert ? dst_idx[SLOT_W-1:0] : '0);
        rsp_c.evicted          = (evict_n != '0);
        rsp_c.evicted_width    = (evict_n != '0) ? vic_w_reg : '0;
        rsp_c.evicted_height   = (evict_n != '0) ? vic_h_reg : '0;
        rsp_c.hit_total        = hits_reg + CNT_W'(hit_reg);
        rsp_c.miss_total       = misses_reg + CNT_W'(!is_flush && !hit_reg);
        rsp_c.eviction_total   = evicts_reg + CNT_W'(evict_n);
        rsp_c.allocation_total = allocs_reg + CNT_W'(insert);
        rsp_c.live_entries     = live_new[LIVE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            live_reg    <= '0;
            hits_reg    <= '0;
            misses_reg  <= '0;
            evicts_reg  <= '0;
            allocs_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (out_free) begin
                        live_reg    <= CW'(live_new);
                        hits_reg    <= rsp_c.hit_total;
                        misses_reg  <= rsp_c.miss_total;
                        evicts_reg  <= rsp_c.eviction_total;
                        allocs_reg  <= rsp_c.allocation_total;
                        state_reg   <= s_valid ? ST_SEARCH : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (state_reg == ST_SEARCH) begin
            hit_reg      <= (|hit_vec) && (req_reg.kind == KIND_ACQUIRE);
            hit_oh_reg   <= hit_vec;
            hit_rank_reg <= hit_rank_c;
            free_any_reg <= link[MAX_ENTRIES].free_seen;
            free_oh_reg  <= free_vec;
            vic_oh_reg   <= vic_vec;
            vic_w_reg    <= link[MAX_ENTRIES].vic_w;
            vic_h_reg    <= link[MAX_ENTRIES].vic_h;
        end
        if (advance) begin
            m_data_reg <= rsp_c;
        end
    end

    `LSKTC_ASSERT(a_live_bound, aclk, aresetn, live_reg <= CW'(MAX_ENTRIES), "live count over depth")
    `LSKTC_ASSERT(a_hit_unique, aclk, aresetn, $onehot0(hit_vec), "key held in two slots")
    `LSKTC_ASSERT(a_rank_unique, aclk, aresetn, $onehot0(vic_vec), "recency ranks not distinct")
    `LSKTC_ASSERT_IMPL(a_dst_exists, aclk, aresetn, (state_reg == ST_UPDATE) && insert && !free_any_reg, $onehot(vic_oh_reg), "full store without a victim")

endmodule

// ===== rtl/core/lsktc_cell.sv =====
// ---------------------------------------------------------------------------
// lsktc_cell
// One slot of the tag store: valid bit, size key and recency rank.
// ---------------------------------------------------------------------------
module lsktc_cell
    import lsktc_pkg::*;
#(
    parameter int unsigned IDX_W = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lsktc_cmd_t        cmd,
    input  logic [IDX_W-1:0]  cmd_rank,
    input  logic              sel,
    input  lsktc_link_t       link_in,
    output lsktc_link_t       link_out,
    output logic              hit,
    output logic              lowest_free,
    output logic              victim,
    output logic [IDX_W-1:0]  rank
);

    logic                valid_reg, valid_next;
    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic [IDX_W-1:0]    rank_reg, rank_next;

    assign hit         = valid_reg && (width_reg == cmd.key_w) && (height_reg == cmd.key_h);
    assign lowest_free = !valid_reg && !link_in.free_seen;
    assign victim      = valid_reg && (rank_reg == cmd_rank);
    assign rank        = rank_reg;

    // Pass the free flag and the victim key down the row
    assign link_out.free_seen = link_in.free_seen || !valid_reg;
    assign link_out.vic_w     = link_in.vic_w | (victim ? width_reg : '0);
    assign link_out.vic_h     = link_in.vic_h | (victim ? height_reg : '0);

    always_comb begin
        valid_next  = valid_reg;
        width_next  = width_reg;
        height_next = height_reg;
        rank_next   = rank_reg;
        unique case (cmd.op)
            OP_FLUSH: begin
                valid_next = 1'b0;
            end
            OP_PROMOTE: begin
                if (sel) begin
                    rank_next = '0;
                end else if (valid_reg && (rank_reg < cmd_rank)) begin
                    rank_next = rank_reg + IDX_W'(1);
                end
            end
            OP_INSERT: begin
                if (sel) begin
                    valid_next  = 1'b1;
                    width_next  = cmd.key_w;
                    height_next = cmd.key_h;
                    rank_next   = '0;
                end else if (valid_reg) begin
                    // drop everything at or beyond the capacity threshold
                    if (rank_reg >= cmd_rank) begin
                        valid_next = 1'b0;
                    end else begin
                        rank_next = rank_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        width_reg  <= width_next;
        height_reg <= height_next;
        rank_reg   <= rank_next;
    end

endmodule
